@@ rtl/wsm_pkg.sv @@
// ----------------------------------------------------------------------------
// wsm_pkg: shared constants and types of the wheel speed meter
// Widths, register indexes and the small structs passed between modules.
// ----------------------------------------------------------------------------
package wsm_pkg;

	// state widths
	localparam int ELAPSED_W = 20;
	localparam int COUNT_W   = 16;
	localparam int GAIN_W    = 10;
	localparam int THR_W     = 8;
	localparam int WINDOW_W  = 12;
	localparam int TIMER_W   = 10;
	localparam int SPEED_W   = 8;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;

	// arithmetic widths
	localparam int PROD_W     = COUNT_W + GAIN_W;
	localparam int DIVIDEND_W = PROD_W + 4;
	localparam int DIVISOR_W  = ELAPSED_W;
	localparam int DSH_W      = DIVISOR_W + SPEED_W;
	localparam int CMP_W      = (DIVIDEND_W > DSH_W) ? DIVIDEND_W : DSH_W;
	localparam int STEP_W     = $clog2(SPEED_W + 1);

	// fast mode divides count*gain by this
	localparam int FAST_DIV = 100;

	// stream word widths
	localparam int IN_W  = 8;
	localparam int OUT_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_A    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_B    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEND      = 3'd5;

	// lamp and report drives from the timer block
	typedef struct packed {
		logic left;
		logic right;
		logic send;
	} lamp_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

@@ rtl/wsm_sat_div.sv @@
// ----------------------------------------------------------------------------
// wsm_sat_div: shared shift-subtract divider with 8-bit saturation
// One range check against divisor<<8 saturates to 255, otherwise eight
// restoring steps give the quotient. A zero divisor always saturates.
// ----------------------------------------------------------------------------
module wsm_sat_div import wsm_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output div_stat_t             stat,
	output logic [SPEED_W-1:0]    quotient
);

	logic                  busy_q;
	logic [STEP_W-1:0]     cnt_q;
	logic [DIVIDEND_W-1:0] rem_q;
	logic [DSH_W-1:0]      dsh_q;
	logic [SPEED_W-1:0]    quo_q;
	logic [CMP_W-1:0]      rem_x;
	logic [CMP_W-1:0]      dsh_x;
	logic                  ge;
	logic                  done;

	// one compare and subtract per cycle
	assign rem_x = CMP_W'(rem_q);
	assign dsh_x = CMP_W'(dsh_q);
	assign ge    = (rem_x >= dsh_x);
	assign done  = busy_q && (((cnt_q == '0) && ge) || (cnt_q == STEP_W'(SPEED_W)));

	assign quotient = (cnt_q == '0) ? {SPEED_W{1'b1}} : {quo_q[SPEED_W-2:0], ge};
	assign stat.busy = busy_q;
	assign stat.done = done;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
			dsh_q <= {divisor, {SPEED_W{1'b0}}};
			quo_q <= '0;
		end else if (busy_q && !done) begin
			if ((cnt_q != '0) && ge) begin
				rem_q <= DIVIDEND_W'(rem_x - dsh_x);
			end
			if (cnt_q != '0) begin
				quo_q <= {quo_q[SPEED_W-2:0], ge};
			end
			dsh_q <= dsh_q >> 1;
		end
	end

endmodule

@@ rtl/wsm_lamp_timers.sv @@
// ----------------------------------------------------------------------------
// wsm_lamp_timers: turn signal phase and report pulse timers
// Both timers advance on the tick of an accepted word; the blinker drives
// are latched at each phase toggle.
// ----------------------------------------------------------------------------
module wsm_lamp_timers import wsm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               tick,
	input  logic               blink_left,
	input  logic               blink_right,
	input  logic [TIMER_W-1:0] blink_half_period,
	input  logic [TIMER_W-1:0] send_period,
	output lamp_t              lamps
);

	logic [TIMER_W-1:0] blink_tmr_q;
	logic [TIMER_W-1:0] send_tmr_q;
	logic               phase_q;
	logic               left_q;
	logic               right_q;
	logic               send_q;
	logic               active;
	logic [TIMER_W-1:0] blink_nxt;
	logic [TIMER_W-1:0] send_nxt;

	assign active = blink_left | blink_right;

	// advanced timer values for this word
	always_comb begin
		blink_nxt = blink_tmr_q;
		if (tick && (blink_tmr_q != '1)) begin
			blink_nxt = blink_tmr_q + 1'b1;
		end
		if (!active) begin
			blink_nxt = '0;
		end
		send_nxt = send_tmr_q;
		if (tick && (send_tmr_q != '1)) begin
			send_nxt = send_tmr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_tmr_q <= '0;
			send_tmr_q  <= '0;
			phase_q     <= 1'b0;
			left_q      <= 1'b0;
			right_q     <= 1'b0;
			send_q      <= 1'b0;
		end else if (step) begin
			// blink phase
			if (blink_nxt >= blink_half_period) begin
				blink_tmr_q <= '0;
				phase_q     <= ~phase_q;
				left_q      <= ~phase_q & blink_left;
				right_q     <= ~phase_q & blink_right;
			end else begin
				blink_tmr_q <= blink_nxt;
			end
			// report pulse
			if (send_nxt >= send_period) begin
				send_tmr_q <= '0;
				send_q     <= 1'b1;
			end else begin
				send_tmr_q <= send_nxt;
				send_q     <= 1'b0;
			end
		end
	end

	assign lamps.left  = left_q;
	assign lamps.right = right_q;
	assign lamps.send  = send_q;

endmodule

@@ rtl/dual_mode_wheel_speed_meter_top.sv @@
// ----------------------------------------------------------------------------
// dual_mode_wheel_speed_meter_top: two-channel wheel speed meter, lamp drive
// Window or interval speed measurement per channel, blinker and report timers.
// ----------------------------------------------------------------------------
// Each channel that produces a new speed passes through a multiply state, a
// load state and the shift-subtract divider shared by both channels.
// The input is taken only while the sequencer is idle; a finished result
// waits in the output register, so the next word can be taken meanwhile.
// The sequencer holds in its completion state while the previous result is
// still unread, so receiver stalls hold up the next word.
module dual_mode_wheel_speed_meter_top import wsm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// tick, pulse_a, pulse_b, head_on, dipped_on, blink_left, blink_right, pad
	input  logic [IN_W-1:0]      s_axis_tdata,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// speed_a[7:0], speed_b[15:8], fast_mode_a, fast_mode_b, head_lamps,
	// dipped_lamps, left_lamp, right_lamp, send_speed, pad
	output logic [OUT_W-1:0]     m_axis_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data
);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_LOAD = 3'd3;
	localparam logic [2:0] S_DIV  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0]            state_q;
	logic                  ch_q;
	logic [THR_W-1:0]      thr_q;
	logic [GAIN_W-1:0]     gain_a_q;
	logic [GAIN_W-1:0]     gain_b_q;
	logic [WINDOW_W-1:0]   window_q;
	logic [TIMER_W-1:0]    blink_per_q;
	logic [TIMER_W-1:0]    send_per_q;
	logic [ELAPSED_W-1:0]  elapsed_a_q;
	logic [ELAPSED_W-1:0]  elapsed_b_q;
	logic [COUNT_W-1:0]    count_a_q;
	logic [COUNT_W-1:0]    count_b_q;
	logic [SPEED_W-1:0]    speed_a_q;
	logic [SPEED_W-1:0]    speed_b_q;
	logic                  mode_a_q;
	logic                  mode_b_q;
	logic                  head_q;
	logic                  dipped_q;
	logic                  fast_q;
	logic [PROD_W-1:0]     prod_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;

	logic                  accept;
	logic                  out_free;
	logic                  out_load;
	logic [ELAPSED_W-1:0]  sel_elapsed;
	logic [COUNT_W-1:0]    sel_count;
	logic [GAIN_W-1:0]     sel_gain;
	logic                  sel_mode;
	logic                  fire;
	logic                  div_start;
	logic [DIVIDEND_W-1:0] dividend;
	logic                  new_mode_a;
	logic                  new_mode_b;
	div_stat_t             div_stat;
	logic [SPEED_W-1:0]    div_quo;
	lamp_t                 lamps;

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid & s_axis_tready;
	assign out_free      = ~out_valid_q | m_axis_tready;
	assign out_load      = (state_q == S_DONE) & out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THR_W'(10);
			gain_a_q    <= GAIN_W'(322);
			gain_b_q    <= GAIN_W'(322);
			window_q    <= WINDOW_W'(1000);
			blink_per_q <= TIMER_W'(500);
			send_per_q  <= TIMER_W'(500);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_THRESHOLD: thr_q       <= cfg_data[THR_W-1:0];
				REG_GAIN_A:    gain_a_q    <= cfg_data[GAIN_W-1:0];
				REG_GAIN_B:    gain_b_q    <= cfg_data[GAIN_W-1:0];
				REG_WINDOW:    window_q    <= cfg_data[WINDOW_W-1:0];
				REG_BLINK:     blink_per_q <= cfg_data[TIMER_W-1:0];
				REG_SEND:      send_per_q  <= cfg_data[TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// channel select and fire decision
	always_comb begin
		sel_elapsed = ch_q ? elapsed_b_q : elapsed_a_q;
		sel_count   = ch_q ? count_b_q : count_a_q;
		sel_gain    = ch_q ? gain_b_q : gain_a_q;
		sel_mode    = ch_q ? mode_b_q : mode_a_q;
		fire        = sel_mode ? (sel_elapsed >= ELAPSED_W'(window_q)) : (sel_count != '0);
	end

	// slow mode scales by ten: p*8 + p*2
	assign dividend  = fast_q ? DIVIDEND_W'(prod_q) :
		DIVIDEND_W'({prod_q, 3'b000}) + DIVIDEND_W'({prod_q, 1'b0});
	assign div_start = (state_q == S_LOAD);

	assign new_mode_a = (speed_a_q > thr_q);
	assign new_mode_b = (speed_b_q > thr_q);

	// sequencer and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ch_q        <= 1'b0;
			elapsed_a_q <= '0;
			elapsed_b_q <= '0;
			count_a_q   <= '0;
			count_b_q   <= '0;
			speed_a_q   <= '0;
			speed_b_q   <= '0;
			mode_a_q    <= 1'b1;
			mode_b_q    <= 1'b1;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (s_axis_tdata[0]) begin
							if (elapsed_a_q != '1) elapsed_a_q <= elapsed_a_q + 1'b1;
							if (elapsed_b_q != '1) elapsed_b_q <= elapsed_b_q + 1'b1;
						end
						if (s_axis_tdata[1] && (count_a_q != '1)) begin
							count_a_q <= count_a_q + 1'b1;
						end
						if (s_axis_tdata[2] && (count_b_q != '1)) begin
							count_b_q <= count_b_q + 1'b1;
						end
						ch_q    <= 1'b0;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (fire) begin
						state_q <= S_MUL;
					end else if (ch_q) begin
						state_q <= S_DONE;
					end else begin
						ch_q <= 1'b1;
					end
				end
				S_MUL: begin
					// operands captured, the channel restarts its measurement
					if (ch_q) begin
						elapsed_b_q <= '0;
						count_b_q   <= '0;
					end else begin
						elapsed_a_q <= '0;
						count_a_q   <= '0;
					end
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						if (ch_q) begin
							speed_b_q <= div_quo;
							state_q   <= S_DONE;
						end else begin
							speed_a_q <= div_quo;
							ch_q      <= 1'b1;
							state_q   <= S_DEC;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						mode_a_q    <= new_mode_a;
						mode_b_q    <= new_mode_b;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// output word valid: set from the completion state, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			head_q   <= s_axis_tdata[3];
			dipped_q <= s_axis_tdata[4];
		end
		if (state_q == S_MUL) begin
			prod_q    <= PROD_W'(sel_count) * PROD_W'(sel_gain);
			fast_q    <= sel_mode;
			divisor_q <= sel_mode ? DIVISOR_W'(FAST_DIV) : sel_elapsed;
		end
		if (out_load) begin
			out_data_q <= {1'b0, lamps.send, lamps.right, lamps.left, dipped_q, head_q,
				new_mode_b, new_mode_a, speed_b_q, speed_a_q};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// shared divider
	wsm_sat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dividend),
		.divisor  (divisor_q),
		.stat     (div_stat),
		.quotient (div_quo)
	);

	// blinker and report timers
	wsm_lamp_timers u_timers (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (accept),
		.tick              (s_axis_tdata[0]),
		.blink_left        (s_axis_tdata[5]),
		.blink_right       (s_axis_tdata[6]),
		.blink_half_period (blink_per_q),
		.send_period       (send_per_q),
		.lamps             (lamps)
	);

`ifndef SYNTHESIS
	// divider finishes only while the sequencer waits for it
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("divider finished outside the divide state");

	// while waiting, the divider is running
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> div_stat.busy)
		else $error("divide state with idle divider");

	// a result is raised only from the completion state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == S_DONE))
		else $error("output word raised outside completion");
`endif

endmodule
